[rtl/sfq_pkg.sv]
package sfq_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Status codes of a result item
  localparam logic [2:0] ST_PUSHED    = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } sfq_cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] match_position;
    logic [4:0] entry_count;
  } sfq_result_t;

  // Per-cycle commands broadcast to every cell of the chain
  typedef struct packed {
    logic push;    // write the value into the cell at the tail
    logic remove;  // cells at or after the hit index take their neighbor's entry
    logic load;    // capture the compare result of every cell
  } sfq_ctrl_t;

endpackage

[rtl/sfq_cell.sv]
module sfq_cell
  import sfq_pkg::*;
#(
  parameter int IW    = 4,
  parameter int CW    = 5,
  parameter int INDEX = 0
) (
  input  logic               clk_i,
  input  sfq_ctrl_t          ctrl_i,
  input  logic [CW-1:0]      count_i,
  input  logic [IW-1:0]      hit_idx_i,
  input  logic signed [31:0] value_i,
  input  logic signed [31:0] next_i,
  output logic signed [31:0] data_o,
  output logic               hit_o
);

  logic signed [31:0] data_q;
  logic               hit_q;
  logic               occupied;

  // A cell holds a live entry when its place lies below the entry count
  assign occupied = CW'(INDEX) < count_i;

  // Write at the tail, or advance the neighbor's entry to close a gap
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push && (count_i == CW'(INDEX))) begin
      data_q <= value_i;
    end else if (ctrl_i.remove && (IW'(INDEX) >= hit_idx_i)) begin
      data_q <= next_i;
    end
  end

  // Hold the compare result for the priority tree
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      hit_q <= occupied && (data_q == value_i);
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

[rtl/sfq_find.sv]
module sfq_find
  import sfq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IW    = 4
) (
  input  logic             clk_i,
  input  logic [DEPTH-1:0] hit_i,
  output logic             any_o,
  output logic [IW-1:0]    idx_o
);

  localparam int P = 1 << IW;

  logic [P-1:0]  leaf;
  logic          node_any_q [1:P-1];
  logic [IW-1:0] node_idx_q [1:P-1];

  // Pad the hit vector to a power of two
  always_comb begin
    leaf = '0;
    leaf[DEPTH-1:0] = hit_i;
  end

  // Registered tree: each node keeps the lowest hit of its two children
  always_ff @(posedge clk_i) begin
    for (int k = 1; k < P; k++) begin
      if (2 * k >= P) begin
        node_any_q[k] <= leaf[2*k-P] | leaf[2*k+1-P];
        node_idx_q[k] <= leaf[2*k-P] ? IW'(2*k-P) : IW'(2*k+1-P);
      end else begin
        node_any_q[k] <= node_any_q[2*k] | node_any_q[2*k+1];
        node_idx_q[k] <= node_any_q[2*k] ? node_idx_q[2*k] : node_idx_q[2*k+1];
      end
    end
  end

  assign any_o = node_any_q[1];
  assign idx_o = node_idx_q[1];

endmodule

[rtl/searchable_fifo_queue.sv]
// Ordered queue of up to DEPTH signed 32-bit values with push, search and
// remove. An item is taken when start is high and busy is low; its result
// appears on result_o for exactly one cycle with done_o high and must be
// taken then, since the block cannot be held off. A push, a search or remove
// on an empty queue, and an unknown operation give their result in the cycle
// after the item is taken, and a new item may follow at once. A search or a
// remove on a queue with entries works in steps: every cell compares its
// entry in the cycle the item is taken, then a registered priority tree of
// log2(DEPTH) levels picks the first match from the head; busy stays high
// meanwhile. On a remove the matched cell and the cells after it take their
// neighbor's entry in the finishing cycle. match_position and entry_count
// carry the low 4 and 5 bits of the position and the count.
module searchable_fifo_queue
  import sfq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  sfq_cmd_t    cmd_i,
  output sfq_result_t result_o,
  output logic        done_o
);

  localparam int IW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int LEVELS = IW;
  localparam int NW     = $clog2(LEVELS + 1);

  typedef enum logic {
    S_IDLE,
    S_FIND
  } state_e;

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic [1:0]         op_q, op_d;
  logic [NW-1:0]      wait_q, wait_d;
  logic               done_q, done_d;
  sfq_result_t        result_q, result_d;

  sfq_ctrl_t          ctrl;
  logic               accept;
  logic               finish;
  logic               root_any;
  logic [IW-1:0]      root_idx;
  logic [DEPTH-1:0]   hits;
  logic signed [31:0] cell_data [DEPTH];

  assign accept = start && (state_q == S_IDLE);
  assign finish = (state_q == S_FIND) && (wait_q == NW'(LEVELS));

  // Drive the cell chain
  always_comb begin
    ctrl.push   = accept && (cmd_i.operation == OP_PUSH) && (count_q != CW'(DEPTH));
    ctrl.load   = accept;
    ctrl.remove = finish && (op_q == OP_REMOVE) && root_any;
  end

  // Chain of cells, each handing its entry toward the head on a remove
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [31:0] nxt;
    if (i == DEPTH - 1) begin : g_last
      assign nxt = cell_data[i];
    end else begin : g_mid
      assign nxt = cell_data[i+1];
    end

    sfq_cell #(
      .IW    (IW),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .count_i   (count_q),
      .hit_idx_i (root_idx),
      .value_i   (cmd_i.value),
      .next_i    (nxt),
      .data_o    (cell_data[i]),
      .hit_o     (hits[i])
    );
  end

  sfq_find #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_find (
    .clk_i (clk_i),
    .hit_i (hits),
    .any_o (root_any),
    .idx_o (root_idx)
  );

  // Next state, count and result
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    op_d     = op_q;
    wait_d   = wait_q;
    done_d   = 1'b0;
    result_d = result_q;
    if (accept) begin
      op_d   = cmd_i.operation;
      wait_d = '0;
      result_d.match_position = '0;
      unique case (cmd_i.operation)
        OP_PUSH: begin
          done_d = 1'b1;
          if (count_q == CW'(DEPTH)) begin
            result_d.status = ST_FULL;
          end else begin
            count_d         = count_q + CW'(1);
            result_d.status = ST_PUSHED;
          end
        end
        OP_SEARCH, OP_REMOVE: begin
          if (count_q == '0) begin
            done_d          = 1'b1;
            result_d.status = ST_EMPTY;
          end else begin
            state_d = S_FIND;
          end
        end
        default: begin
          done_d          = 1'b1;
          result_d.status = ST_NOT_FOUND;
        end
      endcase
      result_d.entry_count = 5'(count_d);
    end else if (finish) begin
      state_d = S_IDLE;
      done_d  = 1'b1;
      if (root_any) begin
        result_d.status         = ST_FOUND;
        result_d.match_position = 4'(root_idx);
        if (op_q == OP_REMOVE) begin
          count_d = count_q - CW'(1);
        end
      end else begin
        result_d.status         = ST_NOT_FOUND;
        result_d.match_position = '0;
      end
      result_d.entry_count = 5'(count_d);
    end else if (state_q == S_FIND) begin
      wait_d = wait_q + NW'(1);
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      op_q     <= OP_PUSH;
      wait_q   <= '0;
      done_q   <= 1'b0;
      result_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      op_q     <= op_d;
      wait_q   <= wait_d;
      done_q   <= done_d;
      result_q <= result_d;
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

[rtl/sfq_checker.sv]
module sfq_checker
  import sfq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input sfq_cmd_t    cmd_i,
  input sfq_result_t result_o,
  input logic        done_o
);

  // A result always leaves the block ready for the next item
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // A push or an unknown operation answers in the next cycle
  a_push_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.operation == OP_PUSH || cmd_i.operation == OP_UNUSED))
      |=> done_o)
    else $error("push item gave no result in the next cycle");

  // Full status only with a full queue
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_FULL) |-> (result_o.entry_count == 5'(DEPTH)))
    else $error("full status with a wrong entry count");

  // Empty status only with no entries
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EMPTY) |-> (result_o.entry_count == '0))
    else $error("empty status with entries held");

  // Only a match carries a position
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_FOUND) |-> (result_o.match_position == '0))
    else $error("position given without a match");

endmodule

bind searchable_fifo_queue sfq_checker #(.DEPTH(DEPTH)) u_sfq_checker (.*);
